/* design/rhb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhb_pkg: shared types and constants for the RGB to HSB converter
// Widths of the color fields, the divider lane format and the chain length.
// ----------------------------------------------------------------------------
package rhb_pkg;

    localparam int PCT_W  = 7;     // percent channel width
    localparam int HUE_W  = 16;
    localparam int SAT_W  = 8;
    localparam int BRI_W  = 8;
    localparam int QUO_W  = 16;    // quotient bits produced by the chain
    localparam int DIV_W  = 10;    // divisor width, six times the channel span
    localparam int NUM_W  = DIV_W + QUO_W;
    localparam int STAGES = QUO_W; // one quotient bit per cell

    // Brightness: floor(255 * max / 100) as a multiply by 5243 / 2^19.
    // Exact for 255 * max up to 32385, the top of the 7-bit field.
    localparam int RECIP_W   = 13;
    localparam int BRI_SHIFT = 19;
    localparam int BPROD_W   = QUO_W + RECIP_W;
    localparam int BQ_W      = BPROD_W - BRI_SHIFT;
    localparam logic [RECIP_W-1:0] BRI_RECIP = RECIP_W'(5243);

    // One long-division lane: partial remainder, divisor, and a word that
    // holds the unconsumed dividend bits on top and the quotient bits below.
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] word;
    } lane_t;

    typedef struct packed {
        lane_t            hue;
        lane_t            sat;
        logic [BRI_W-1:0] bri;
    } token_t;

endpackage

/* design/rhb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhb_front: sector decode and dividend setup
// Finds max, min and the hue sector, loads the two divider lanes and
// forms the brightness.
// ----------------------------------------------------------------------------
module rhb_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rhb_pkg::PCT_W-1:0] red_pct,
    input  logic [rhb_pkg::PCT_W-1:0] green_pct,
    input  logic [rhb_pkg::PCT_W-1:0] blue_pct,
    output logic                     valid,
    output rhb_pkg::token_t          tok
);
    import rhb_pkg::*;

    logic [PCT_W-1:0] mx;
    logic [PCT_W-1:0] mn;
    logic [PCT_W-1:0] d;
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] g;
    logic [DIV_W-1:0] b;
    logic [DIV_W-1:0] d1;
    logic [DIV_W-1:0] d2;
    logic [DIV_W-1:0] d4;
    logic [DIV_W-1:0] d6;
    logic [DIV_W-1:0] n;
    logic [NUM_W-1:0] hue_num;
    logic [QUO_W-1:0] sat_num;
    logic [QUO_W-1:0] bri_num;
    logic [BPROD_W-1:0] bri_prod;
    logic [BQ_W-1:0]  bri_q;
    token_t           tok_next;
    logic             valid_reg;
    token_t           tok_reg;

    always_comb
    begin
        mx = red_pct;
        mn = red_pct;
        if (green_pct > mx) mx = green_pct;
        if (blue_pct > mx)  mx = blue_pct;
        if (green_pct < mn) mn = green_pct;
        if (blue_pct < mn)  mn = blue_pct;
        d  = mx - mn;
        r  = DIV_W'(red_pct);
        g  = DIV_W'(green_pct);
        b  = DIV_W'(blue_pct);
        d1 = DIV_W'(d);
        d2 = d1 << 1;
        d4 = d1 << 2;
        d6 = d4 + d2;
    end

    // Position within the hexcone, 0 <= n < 6d.
    always_comb
    begin
        priority if (r >= g && g >= b)
            n = g - b;
        else if (g > r && r >= b)
            n = d2 - (r - b);
        else if (g >= b && b > r)
            n = d2 + (b - r);
        else if (b > g && g > r)
            n = d4 - (g - r);
        else if (b > r && r >= g)
            n = d4 + (r - g);
        else
            n = d6 - (b - g);
    end

    always_comb
    begin
        // 65535 * n and 255 * x as shift and subtract
        hue_num = {n, {QUO_W{1'b0}}} - NUM_W'(n);
        sat_num = QUO_W'({d, 8'b0}) - QUO_W'(d);
        bri_num = QUO_W'({mx, 8'b0}) - QUO_W'(mx);

        // Divide by 100 with a reciprocal multiply; clamp above 100 percent.
        bri_prod = BPROD_W'(bri_num) * BPROD_W'(BRI_RECIP);
        bri_q    = bri_prod[BPROD_W-1:BRI_SHIFT];

        if (d == '0)
        begin
            tok_next.hue.rem  = '0;
            tok_next.hue.dvs  = DIV_W'(1);
            tok_next.hue.word = '0;
        end
        else
        begin
            tok_next.hue.rem  = hue_num[NUM_W-1:QUO_W];
            tok_next.hue.dvs  = d6;
            tok_next.hue.word = hue_num[QUO_W-1:0];
        end

        tok_next.sat.rem  = '0;
        tok_next.sat.dvs  = (mx == '0) ? DIV_W'(1) : DIV_W'(mx);
        tok_next.sat.word = sat_num;

        tok_next.bri = (bri_q[BQ_W-1:BRI_W] != '0) ? {BRI_W{1'b1}} : bri_q[BRI_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign valid = valid_reg;
    assign tok   = tok_reg;

endmodule

/* design/rhb_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhb_cell: one restoring division step on the hue and saturation lanes
// Retire one quotient bit per lane, carry brightness, and hand the beat on.
// ----------------------------------------------------------------------------
module rhb_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            feed_valid,
    input  rhb_pkg::token_t feed_tok,
    output logic            hold_valid,
    output rhb_pkg::token_t hold_tok
);
    import rhb_pkg::*;

    logic   valid_reg;
    token_t tok_reg;
    token_t tok_next;

    function automatic lane_t div_step(input lane_t ln);
        logic [DIV_W:0] t;
        logic           ge;
        lane_t          res;
        t  = {ln.rem, ln.word[QUO_W-1]};
        ge = (t >= {1'b0, ln.dvs});
        res.dvs  = ln.dvs;
        res.rem  = ge ? DIV_W'(t - {1'b0, ln.dvs}) : t[DIV_W-1:0];
        res.word = {ln.word[QUO_W-2:0], ge};
        return res;
    endfunction

    always_comb
    begin
        tok_next.hue = div_step(feed_tok.hue);
        tok_next.sat = div_step(feed_tok.sat);
        tok_next.bri = feed_tok.bri;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= feed_valid;
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign hold_valid = valid_reg;
    assign hold_tok   = tok_reg;

endmodule

/* design/rgb_to_hsb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsb: percent RGB to hexcone hue, saturation and brightness
// A setup stage followed by a row of 16 division cells, one quotient bit each.
// ----------------------------------------------------------------------------
// Path: a start beat is registered by the setup stage and then by each of the 16 cells; done is the last cell's valid.
// Throughput: one color per clock; busy is always low and start is taken
// in every cycle. The rate is set by the cell row: every cell is a register
// stage, so 17 colors can be in flight at once.
// Reset: rst_n clears the valid bits of the setup stage and all cells; data
// registers are not reset. The receiver cannot stall, so done is a pulse.
// ----------------------------------------------------------------------------
module rgb_to_hsb (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rhb_pkg::PCT_W-1:0] red_pct,
    input  logic [rhb_pkg::PCT_W-1:0] green_pct,
    input  logic [rhb_pkg::PCT_W-1:0] blue_pct,
    output logic                      done,
    output logic [rhb_pkg::HUE_W-1:0] hue_out,
    output logic [rhb_pkg::SAT_W-1:0] sat_out,
    output logic [rhb_pkg::BRI_W-1:0] bri_out
);
    import rhb_pkg::*;

    // Link k feeds cell k; link 0 comes from the setup stage and the last
    // link holds the finished quotients.
    logic   link_valid [0:STAGES];
    token_t link_tok   [0:STAGES];
    token_t fin;

    // Every beat flows through the row without holding, so never push back.
    assign busy = 1'b0;

    // Setup: max/min, hue sector, the two dividends and the brightness,
    // which is clamped here when a channel is above 100 percent.
    rhb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .red_pct   (red_pct),
        .green_pct (green_pct),
        .blue_pct  (blue_pct),
        .valid     (link_valid[0]),
        .tok       (link_tok[0])
    );

    // Division row: each cell retires one quotient bit of hue and saturation,
    // most significant bit first, carries the brightness along, and advances
    // the beat.
    for (genvar k = 0; k < STAGES; k++)
    begin : g_cell
        rhb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .feed_valid (link_valid[k]),
            .feed_tok   (link_tok[k]),
            .hold_valid (link_valid[k+1]),
            .hold_tok   (link_tok[k+1])
        );
    end

    assign fin  = link_tok[STAGES];
    assign done = link_valid[STAGES];

    // Hue and saturation quotients fit by construction.
    assign hue_out = fin.hue.word[HUE_W-1:0];
    assign sat_out = fin.sat.word[SAT_W-1:0];
    assign bri_out = fin.bri;

endmodule

/* dv/tb_rgb_to_hsb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsb: self-checking bench for the percent RGB to HSB converter
// Colors are queued and driven as start beats. Each accepted beat gets a
// predicted hue, saturation and brightness, and every done pulse is checked
// against the oldest prediction. A short directed list goes first, then
// random colors in phases with different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsb;
    import rhb_pkg::*;

    // Scale factors of the conversion.
    localparam int unsigned HUE_SCALE  = 65535;
    localparam int unsigned CHAN_SCALE = 255;
    localparam int unsigned PCT_FULL   = 100;

    // Watchdog limit on cycles with neither a start beat nor a done pulse.
    // The worst gap is a long run of sender idles plus the trip through the setup stage and the cell row.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to keep watching after the last result, for stray done pulses.
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_PER_PHASE = 212;
    localparam int NUM_PHASES = 4;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PCT_W-1:0] red;
        logic [PCT_W-1:0] green;
        logic [PCT_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [BRI_W-1:0] bri;
    } hsb_t;

    // One outstanding conversion: the color that went in and what must come out.
    typedef struct packed {
        color_t src;
        hsb_t   val;
    } conversion_t;

    // Sender idle percentage per phase: none, heavy, moderate, none again.
    localparam int PHASE_IDLE [NUM_PHASES] = '{0, 79, 33, 0};

    // Channel values at the edges of the percent range and of the 7-bit field.
    localparam int EDGE_VALS [7] = '{0, 1, 99, 100, 101, 126, 127};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [PCT_W-1:0] red_pct = '0;
    logic [PCT_W-1:0] green_pct = '0;
    logic [PCT_W-1:0] blue_pct = '0;
    logic done;
    logic [HUE_W-1:0] hue_out;
    logic [SAT_W-1:0] sat_out;
    logic [BRI_W-1:0] bri_out;

    color_t      colors_pending[$];  // colors waiting to be driven
    conversion_t hsb_due[$];         // predictions waiting for a done pulse

    int unsigned queued = 0;       // colors handed to the driver
    int unsigned accepted = 0;     // start beats taken by the block
    int unsigned converted = 0;    // done pulses matched to a prediction
    int unsigned quiet_cycles = 0; // cycles since the last beat or result
    int unsigned errors = 0;
    int          idle_pct = 0;
    bit          took_beat = 1'b0; // the beat on the pins was taken last edge
    bit          timed_out = 1'b0;

    rgb_to_hsb dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .red_pct  (red_pct),
        .green_pct(green_pct),
        .blue_pct (blue_pct),
        .done     (done),
        .hue_out  (hue_out),
        .sat_out  (sat_out),
        .bri_out  (bri_out)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction: hexcone hue from the sector that max and min select, with
    // every quotient an exact integer floor.
    // ------------------------------------------------------------------------
    function automatic hsb_t hsb_of(color_t c);
        int unsigned r, g, b, hi, lo, span, num, bri;
        hsb_t res;
        r = c.red;
        g = c.green;
        b = c.blue;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        res = '0;
        // All channels zero leaves everything at zero.
        if (hi != 0) begin
            // A gray (all channels equal) keeps hue at zero.
            if (span != 0) begin
                if (r >= g && g >= b)
                    num = g - b;
                else if (g > r && r >= b)
                    num = 2 * span - (r - b);
                else if (g >= b && b > r)
                    num = 2 * span + (b - r);
                else if (b > g && g > r)
                    num = 4 * span - (g - r);
                else if (b > r && r >= g)
                    num = 4 * span + (r - g);
                else
                    num = 6 * span - (b - g);
                res.hue = HUE_W'((HUE_SCALE * num) / (6 * span));
            end
            res.sat = SAT_W'((CHAN_SCALE * span) / hi);
            // Channels above 100 percent would overflow brightness: clamp.
            bri = (hi * CHAN_SCALE) / PCT_FULL;
            if (bri > CHAN_SCALE)
                bri = CHAN_SCALE;
            res.bri = BRI_W'(bri);
        end
        return res;
    endfunction

    function automatic void note_mismatch(string what, color_t c,
                                          int unsigned want, int unsigned got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch for rgb (%0d, %0d, %0d): expected %0d, got %0d",
                     $realtime, what, c.red, c.green, c.blue, want, got);
    endfunction

    task automatic queue_color(int r, int g, int b);
        colors_pending.push_back(color_t'{PCT_W'(r), PCT_W'(g), PCT_W'(b)});
        queued++;
    endtask

    // Block until every queued color has been accepted and converted, or the
    // watchdog trips. Sampled at the falling edge, where the counters are stable.
    task automatic wait_drained();
        while (!timed_out && (accepted != queued || converted != accepted)) begin
            @(negedge clk);
            if (quiet_cycles >= QUIET_LIMIT)
                timed_out = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs at the falling edge only. Hold a beat until it is
    // taken; then either advance to the next color or idle, as the phase says.
    // While idle, put random noise on the color pins.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        color_t nxt;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (!start || took_beat) begin
            if (colors_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = colors_pending.pop_front();
                start     <= 1'b1;
                red_pct   <= nxt.red;
                green_pct <= nxt.green;
                blue_pct  <= nxt.blue;
            end
            else begin
                start     <= 1'b0;
                red_pct   <= PCT_W'($urandom);
                green_pct <= PCT_W'($urandom);
                blue_pct  <= PCT_W'($urandom);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check a done pulse against the
    // oldest prediction first, then record a new prediction for a taken beat.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        conversion_t oldest;
        hsb_t        seen;
        if (rst_n) begin
            if (done) begin
                seen = hsb_t'{hue_out, sat_out, bri_out};
                if (hsb_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: done pulse with no conversion outstanding", $realtime);
                end
                else begin
                    oldest = hsb_due.pop_front();
                    if (seen.hue !== oldest.val.hue)
                        note_mismatch("hue", oldest.src, oldest.val.hue, seen.hue);
                    if (seen.sat !== oldest.val.sat)
                        note_mismatch("saturation", oldest.src, oldest.val.sat, seen.sat);
                    if (seen.bri !== oldest.val.bri)
                        note_mismatch("brightness", oldest.src, oldest.val.bri, seen.bri);
                    converted <= converted + 1;
                end
            end
            if (start && !busy) begin
                oldest.src = color_t'{red_pct, green_pct, blue_pct};
                oldest.val = hsb_of(oldest.src);
                hsb_due.push_back(oldest);
                accepted <= accepted + 1;
            end
            took_beat <= start && !busy;
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned base;
        int r, g, b;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES && !timed_out; p++) begin
            idle_pct = PHASE_IDLE[p];
            if (p == 0) begin
                // Black, grays, and the top of the 7-bit field.
                queue_color(0, 0, 0);
                queue_color(50, 50, 50);
                queue_color(100, 100, 100);
                queue_color(127, 127, 127);
                // One color per hue sector, ties on the sector borders too.
                queue_color(100, 60, 20);   // red >= green >= blue
                queue_color(80, 80, 10);    // red equals green
                queue_color(60, 100, 20);   // green > red >= blue
                queue_color(20, 100, 20);   // red equals blue, green on top
                queue_color(20, 100, 60);   // green >= blue > red
                queue_color(10, 80, 80);    // green equals blue
                queue_color(20, 60, 100);   // blue > green > red
                queue_color(60, 20, 100);   // blue > red >= green
                queue_color(30, 30, 90);    // red equals green, blue on top
                queue_color(100, 20, 60);   // red >= blue > green
                queue_color(90, 10, 90);    // red equals blue
                // Single channels and extremes, including above 100 percent.
                queue_color(100, 0, 0);
                queue_color(0, 100, 0);
                queue_color(0, 0, 100);
                queue_color(127, 0, 0);
                queue_color(0, 127, 0);
                queue_color(0, 0, 127);
                queue_color(1, 0, 0);
                queue_color(0, 0, 1);
                queue_color(101, 100, 99);
                queue_color(127, 1, 126);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: begin
                        // Nominal percent range.
                        r = $urandom_range(100);
                        g = $urandom_range(100);
                        b = $urandom_range(100);
                    end
                    6: begin
                        // Whole field, out-of-range channels included.
                        r = $urandom_range(127);
                        g = $urandom_range(127);
                        b = $urandom_range(127);
                    end
                    7, 8: begin
                        // Near-gray: tiny span, hardest on the hue divide.
                        base = $urandom_range(124);
                        r = base + $urandom_range(3);
                        g = base + $urandom_range(3);
                        b = base + $urandom_range(3);
                    end
                    default: begin
                        r = EDGE_VALS[$urandom_range(6)];
                        g = EDGE_VALS[$urandom_range(6)];
                        b = EDGE_VALS[$urandom_range(6)];
                    end
                endcase
                queue_color(r, g, b);
            end
            wait_drained();
        end

        // Watch for stray done pulses after the last result.
        if (!timed_out)
            repeat (TAIL_CYCLES) @(negedge clk);
        if (timed_out)
            $display("%0t: watchdog expired after %0d quiet cycles", $realtime, quiet_cycles);
        if (hsb_due.size() != 0)
            $display("%0d conversions never completed", hsb_due.size());

        if (timed_out || errors != 0 || hsb_due.size() != 0)
            $display("end of test: mismatches");
        else
            $display("end of test: clean");
        $finish;
    end

endmodule

/* rgb_to_hsb.f */
design/rhb_pkg.sv
design/rhb_front.sv
design/rhb_cell.sv
design/rgb_to_hsb.sv
dv/tb_rgb_to_hsb.sv
